// ===== sv/keyboard_mouse_packet_decoder_unit_macros.svh =====
// Assertion macros for the keyboard/mouse packet decoder.
// Included by the top level; no other dependencies.
`ifndef KEYBOARD_MOUSE_PACKET_DECODER_UNIT_MACROS_SVH
`define KEYBOARD_MOUSE_PACKET_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, off during reset
`define KMPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmpd: same-cycle check failed");

// Next-cycle implication, off during reset
`define KMPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmpd: next-cycle check failed");

`else

`define KMPD_ASSERT_NOW(label, clk, rst, ante, cons)
`define KMPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/kmpd_pkg.sv =====
// Shared types and constants for the keyboard/mouse packet decoder.
// No dependencies; imported by every module of the block.
package kmpd_pkg;

  // Fixed field widths
  localparam int LIMIT_W   = 10;
  localparam int CURSOR_W  = 10;
  localparam int KEY_W     = 7;
  localparam int CLICK_W   = 2;

  // Default cursor register width
  localparam int COORD_WIDTH_DEF = 10;

  // Item opcodes
  localparam logic OP_RX     = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Link byte codes
  localparam logic [7:0] HDR_MIN     = 8'hF8;
  localparam logic [7:0] BYTE_MAX    = 8'hFF;
  localparam logic [7:0] BTN_NONE    = 8'hF8;
  localparam logic [7:0] BTN_FIRST   = 8'hF9;
  localparam logic [7:0] BTN_SECOND  = 8'hFA;

  // Click codes
  localparam logic [CLICK_W-1:0] CLICK_NONE   = 2'd0;
  localparam logic [CLICK_W-1:0] CLICK_FIRST  = 2'd1;
  localparam logic [CLICK_W-1:0] CLICK_SECOND = 2'd2;

  // Configuration register indexes
  localparam logic CFG_X_LIMIT = 1'b0;
  localparam logic CFG_Y_LIMIT = 1'b1;

  // Reset values
  localparam logic [LIMIT_W-1:0] X_LIMIT_RESET = 10'd628;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RESET = 10'd378;
  localparam int POS_X_RESET = 320;
  localparam int POS_Y_RESET = 200;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                key_valid;
    logic [KEY_W-1:0]    key_code;
    logic [CURSOR_W-1:0] cursor_x;
    logic [CURSOR_W-1:0] cursor_y;
    logic [CLICK_W-1:0]  click;
  } out_item_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
  } limits_t;

endpackage

// ===== sv/kmpd_clamp.sv =====
// One cursor axis: signed 8-bit delta add, clamp to 0..limit.
// Depends on kmpd_pkg.
module kmpd_clamp #(
  parameter int COORD_WIDTH = kmpd_pkg::COORD_WIDTH_DEF
) (
  input  logic [COORD_WIDTH-1:0]       pos,
  input  logic [7:0]                   delta,
  input  logic [kmpd_pkg::LIMIT_W-1:0] limit,
  output logic [COORD_WIDTH-1:0]       pos_next
);
  import kmpd_pkg::*;

  // Working width: covers the wider of coordinate and limit, plus carry and sign
  localparam int EW = ((COORD_WIDTH > LIMIT_W) ? COORD_WIDTH : LIMIT_W) + 2;
  localparam logic [EW-1:0] COORD_MAX_E = {{(EW-COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}};

  logic signed [EW-1:0] pos_e;
  logic signed [EW-1:0] delta_e;
  logic signed [EW-1:0] sum;
  logic signed [EW-1:0] lim_e;
  logic [EW-1:0]        limit_u;
  logic [EW-1:0]        res;

  always_comb begin
    pos_e   = signed'({{(EW-COORD_WIDTH){1'b0}}, pos});
    delta_e = signed'({{(EW-8){delta[7]}}, delta});
    sum     = pos_e + delta_e;
    limit_u = {{(EW-LIMIT_W){1'b0}}, limit};
    // limit saturates at what the coordinate register holds
    lim_e   = signed'((limit_u > COORD_MAX_E) ? COORD_MAX_E : limit_u);
    if (sum < 0) begin
      res = '0;
    end else if (sum > lim_e) begin
      res = unsigned'(lim_e);
    end else begin
      res = unsigned'(sum);
    end
    pos_next = res[COORD_WIDTH-1:0];
  end

endmodule

// ===== sv/kmpd_core.sv =====
// Decoder state and single-pass step logic: packet phase, deltas, cursor, click.
// Depends on kmpd_pkg and kmpd_clamp.
module kmpd_core #(
  parameter int COORD_WIDTH = kmpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  kmpd_pkg::in_item_t  item,
  input  kmpd_pkg::limits_t   limits,
  output kmpd_pkg::out_item_t result
);
  import kmpd_pkg::*;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_DX   = 2'd1;
  localparam logic [1:0] PHASE_DY   = 2'd2;

  localparam int CMAX = (1 << COORD_WIDTH) - 1;
  localparam logic [COORD_WIDTH-1:0] POS_X_INIT =
    COORD_WIDTH'((POS_X_RESET > CMAX) ? CMAX : POS_X_RESET);
  localparam logic [COORD_WIDTH-1:0] POS_Y_INIT =
    COORD_WIDTH'((POS_Y_RESET > CMAX) ? CMAX : POS_Y_RESET);

  logic [1:0]             packet_phase, packet_phase_next;
  logic [7:0]             button_byte, button_byte_next;
  logic [7:0]             delta_x, delta_x_next;
  logic [7:0]             delta_y, delta_y_next;
  logic [COORD_WIDTH-1:0] pos_x, pos_x_next;
  logic [COORD_WIDTH-1:0] pos_y, pos_y_next;
  logic [CLICK_W-1:0]     click_code, click_code_next;
  logic [COORD_WIDTH-1:0] moved_x, moved_y;
  logic                   kv;
  logic [KEY_W-1:0]       kc;
  logic [CURSOR_W+COORD_WIDTH-1:0] out_x_wide, out_y_wide;

  kmpd_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_x (
    .pos(pos_x), .delta(delta_x), .limit(limits.x_limit), .pos_next(moved_x)
  );

  kmpd_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_y (
    .pos(pos_y), .delta(delta_y), .limit(limits.y_limit), .pos_next(moved_y)
  );

  always_comb begin
    packet_phase_next = packet_phase;
    button_byte_next  = button_byte;
    delta_x_next      = delta_x;
    delta_y_next      = delta_y;
    pos_x_next        = pos_x;
    pos_y_next        = pos_y;
    click_code_next   = click_code;
    kv                = 1'b0;
    kc                = '0;
    if (step_en) begin
      case (item.op)
        OP_RX: begin
          case (packet_phase)
            PHASE_IDLE: begin
              if (item.rx_byte inside {[HDR_MIN:BYTE_MAX]}) begin
                button_byte_next  = item.rx_byte;
                packet_phase_next = PHASE_DX;
              end else if (!item.rx_byte[7]) begin
                kv = 1'b1;
                kc = item.rx_byte[KEY_W-1:0];
              end
            end
            PHASE_DX: begin
              delta_x_next      = item.rx_byte;
              packet_phase_next = PHASE_DY;
            end
            PHASE_DY: begin
              delta_y_next      = item.rx_byte;
              packet_phase_next = PHASE_IDLE;
            end
            default: begin
              packet_phase_next = PHASE_IDLE;
            end
          endcase
        end
        OP_UPDATE: begin
          pos_x_next   = moved_x;
          pos_y_next   = moved_y;
          delta_x_next = '0;
          delta_y_next = '0;
          case (button_byte)
            BTN_NONE:   click_code_next = CLICK_NONE;
            BTN_FIRST:  click_code_next = CLICK_FIRST;
            BTN_SECOND: click_code_next = CLICK_SECOND;
            default:    click_code_next = click_code;
          endcase
        end
        default: begin
          packet_phase_next = packet_phase;
        end
      endcase
    end

    // result shows the state after this step; cursor masked to output width
    out_x_wide       = {{CURSOR_W{1'b0}}, pos_x_next};
    out_y_wide       = {{CURSOR_W{1'b0}}, pos_y_next};
    result.key_valid = kv;
    result.key_code  = kc;
    result.cursor_x  = out_x_wide[CURSOR_W-1:0];
    result.cursor_y  = out_y_wide[CURSOR_W-1:0];
    result.click     = click_code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_phase <= PHASE_IDLE;
      button_byte  <= BTN_NONE;
      delta_x      <= '0;
      delta_y      <= '0;
      pos_x        <= POS_X_INIT;
      pos_y        <= POS_Y_INIT;
      click_code   <= CLICK_NONE;
    end else begin
      packet_phase <= packet_phase_next;
      button_byte  <= button_byte_next;
      delta_x      <= delta_x_next;
      delta_y      <= delta_y_next;
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
      click_code   <= click_code_next;
    end
  end

endmodule

// ===== sv/keyboard_mouse_packet_decoder_unit.sv =====
// Top level of the keyboard/mouse packet decoder: input register, step core,
// result register, limit registers. Depends on kmpd_pkg, kmpd_core and the macros header.
//
// Decodes bytes from a keyboard controller link into key press codes and a
// clamped mouse cursor. Every accepted input transfer yields exactly one result
// transfer. A link byte (op 0) of 0xF8..0xFF in the idle phase opens a relative
// mouse packet; the next two bytes are the signed X and Y deltas. Idle bytes
// below 0x80 come out as key presses with key_valid set; other idle bytes are
// dropped (result still issued, key_valid low). An update (op 1) adds the stored
// deltas to the cursor, clamps each axis to 0..limit, clears the deltas and maps
// the last button byte to a click code. Every result carries the cursor and
// click as they stand after that item. Throughput is one item per clock while
// out_ready keeps the result register draining; an item waits in the input
// register and is computed on its way into the result register.
// The input register and result register let a new item be taken while a result
// waits on out_ready. The x_limit/y_limit registers (index 0 and 1) are written
// through the cfg port, which is always ready; write them only while idle.
`include "keyboard_mouse_packet_decoder_unit_macros.svh"

module keyboard_mouse_packet_decoder_unit #(
  parameter int COORD_WIDTH = kmpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // item input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kmpd_pkg::in_item_t             in_data,
  // result output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output kmpd_pkg::out_item_t            out_data,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [kmpd_pkg::LIMIT_W-1:0]   cfg_data
);
  import kmpd_pkg::*;

  // input register
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_adv;

  limits_t   limits;
  out_item_t step_result;

  // The item in the input register moves on when the result slot is free
  // or is being emptied this cycle.
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.x_limit <= X_LIMIT_RESET;
      limits.y_limit <= Y_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_LIMIT: limits.x_limit <= cfg_data;
        CFG_Y_LIMIT: limits.y_limit <= cfg_data;
        default:     limits.x_limit <= limits.x_limit;
      endcase
    end
  end

  // state update happens exactly once per item, on the transfer into the result slot
  kmpd_core #(.COORD_WIDTH(COORD_WIDTH)) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (s1_adv),
    .item    (s1_item),
    .limits  (limits),
    .result  (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= step_result;
    end
  end

  // an item leaving the input register always lands in the result slot
  `KMPD_ASSERT_NEXT(a_adv_lands, clk, rst, s1_adv, out_valid)

  // after an update the cursor sits within the programmed limits
  `KMPD_ASSERT_NEXT(a_x_in_limit, clk, rst, s1_adv && (s1_item.op == OP_UPDATE) && !cfg_valid, out_data.cursor_x <= limits.x_limit)

  `KMPD_ASSERT_NEXT(a_y_in_limit, clk, rst, s1_adv && (s1_item.op == OP_UPDATE) && !cfg_valid, out_data.cursor_y <= limits.y_limit)

  // a key code only ever accompanies key_valid
  `KMPD_ASSERT_NOW(a_key_code_zero, clk, rst, out_valid && !out_data.key_valid, out_data.key_code == '0)

endmodule
